// ===== hw/rtl/mgc_pkg.sv =====
`timescale 1ns / 1ps

package mgc_pkg;

   localparam int unsigned MGC_QUEUE_DEPTH = 4;

   localparam logic [1:0] RULE_198  = 2'd0;
   localparam logic [1:0] RULE_2565 = 2'd1;
   localparam logic [1:0] RULE_7883 = 2'd2;

   localparam logic REG_RULE = 1'b0;
   localparam logic REG_CAP  = 1'b1;

   localparam logic [1:0] RULE_RESET = RULE_7883;
   localparam logic       CAP_RESET  = 1'b1;

   localparam logic [63:0] LEN_CAP        = 64'd1024;
   localparam logic [63:0] HEAD_LEN       = 64'd32;
   localparam logic [63:0] SQ_LIMIT_198   = 64'd64;
   localparam logic [63:0] MIN_GAS_2565   = 64'd200;
   localparam logic [63:0] MIN_GAS_7883   = 64'd500;
   localparam logic [77:0] OFF_198_MID    = 78'd3072;
   localparam logic [77:0] OFF_198_HIGH   = 78'd199680;
   localparam logic [46:0] LIN_198_MID    = 47'd96;
   localparam logic [46:0] LIN_198_HIGH   = 47'd480;
   localparam logic [77:0] FLOOR_7883     = 78'd16;
   localparam logic [73:0] DIV_198        = 74'd20;
   localparam logic [73:0] DIV_2565       = 74'd3;
   localparam logic [73:0] DIV_7883       = 74'd1;
   // 1/5 and 1/3 as fixed-point reciprocals for one-digit division
   localparam logic [22:0] RECIP_5        = 23'd3277;
   localparam logic [22:0] RECIP_3        = 23'd683;
   localparam logic [10:0] DIGIT_DIV_198  = 11'd5;
   localparam logic [10:0] DIGIT_DIV_2565 = 11'd3;

   typedef struct packed {
      logic [1:0]   rule;
      logic         fin;
      logic [63:0]  fin_gas;
      logic         fin_inv;
      logic [63:0]  base_len;
      logic [63:0]  exp_len;
      logic [63:0]  mod_len;
      logic [255:0] head;
   } cls_type;

   typedef struct packed {
      logic [1:0]       rule;
      logic             fin;
      logic [63:0]      fin_gas;
      logic             fin_inv;
      logic             sat;
      logic [63:0]      mlen;
      logic             el_big;
      logic [63:0]      el_off;
      logic [3:0][6:0]  wlen;
      logic [67:0]      iter;
      logic [37:0]      x;
      logic [37:0]      pp_hh;
      logic [37:0]      pp_hl;
      logic [37:0]      pp_ll;
      logic [46:0]      lin;
      logic [75:0]      sq;
      logic [68:0]      cplx;
      logic [8:0][45:0] pp;
      logic [2:0][91:0] row;
      logic [137:0]     prod;
      logic [71:0]      num;
      logic [71:0]      quo;
      logic [2:0]       rem;
   } bk_type;

   function automatic logic [63:0] min_gas(input logic [1:0] rule);
      logic [63:0] g;
      case (rule)
         RULE_198:  g = '0;
         RULE_2565: g = MIN_GAS_2565;
         default:   g = MIN_GAS_7883;
      endcase
      return g;
   endfunction

   function automatic logic [6:0] bit_len64(input logic [63:0] x);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = 7'(i + 1);
      end
      return n;
   endfunction

   // {quotient, remainder} of one 8-bit digit with incoming remainder
   function automatic logic [10:0] div_digit(input logic [10:0] v, input logic [1:0] rule);
      logic [22:0] t;
      logic [7:0]  q;
      logic [10:0] r;
      t = '0;
      case (rule)
         RULE_198: begin
            t = 23'(v) * RECIP_5;
            q = t[21:14];
            r = v - 11'(q) * DIGIT_DIV_198;
         end
         RULE_2565: begin
            t = 23'(v) * RECIP_3;
            q = t[18:11];
            r = v - 11'(q) * DIGIT_DIV_2565;
         end
         default: begin
            q = v[7:0];
            r = '0;
         end
      endcase
      return {q, r[2:0]};
   endfunction

endpackage

// ===== hw/rtl/mgc_front.sv =====
`timescale 1ns / 1ps

module mgc_front
   import mgc_pkg::*;
(
   input  logic [1:0]  cfg_rule,
   input  logic        cfg_cap,
   input  logic [63:0] base_length,
   input  logic        base_length_over,
   input  logic [63:0] exponent_length,
   input  logic        exponent_length_over,
   input  logic [63:0] modulus_length,
   input  logic        modulus_length_over,
   input  logic [63:0] head_word3,
   input  logic [63:0] head_word2,
   input  logic [63:0] head_word1,
   input  logic [63:0] head_word0,
   output cls_type     word
);

   logic [1:0] rule;
   logic       any_over;
   logic       too_long;

   always_comb begin
      rule = (cfg_rule == RULE_198 || cfg_rule == RULE_2565) ? cfg_rule : RULE_7883;
      any_over = base_length_over | exponent_length_over | modulus_length_over;
      too_long = any_over || (base_length > LEN_CAP) || (exponent_length > LEN_CAP)
               || (modulus_length > LEN_CAP);

      word.rule     = rule;
      word.fin      = 1'b0;
      word.fin_gas  = '0;
      word.fin_inv  = 1'b0;
      word.base_len = base_length;
      word.exp_len  = exponent_length;
      word.mod_len  = modulus_length;
      word.head     = {head_word3, head_word2, head_word1, head_word0};

      if (rule != RULE_7883 && base_length == '0 && !base_length_over
          && modulus_length == '0 && !modulus_length_over) begin
         word.fin     = 1'b1;
         word.fin_gas = min_gas(rule);
      end else if (cfg_cap) begin
         if (too_long) begin
            word.fin     = 1'b1;
            word.fin_inv = 1'b1;
         end
      end else if (any_over) begin
         word.fin     = 1'b1;
         word.fin_gas = '1;
      end
   end

endmodule

// ===== hw/rtl/mgc_queue.sv =====
`timescale 1ns / 1ps

module mgc_queue
   import mgc_pkg::*;
#(
   parameter int unsigned DEPTH = MGC_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_word,
   input  logic    pop,
   output cls_type head_word,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cls_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_word;
   end

   assign head_word = mem_ff[rd_ff];
   assign full      = (cnt_ff == CW'(DEPTH));
   assign empty     = (cnt_ff == '0);

endmodule

// ===== hw/rtl/mgc_back.sv =====
`timescale 1ns / 1ps

module mgc_back
   import mgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cls_type     q_word,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_gas,
   output logic        rsp_invalid
);

   localparam int unsigned NST = 12;

   bk_type       st_in [1:NST];
   bk_type       st_ff [1:NST];
   logic [NST:1] vld_ff;
   logic         rsp_valid_ff;
   logic [63:0]  rsp_gas_ff, rsp_gas_in;
   logic         rsp_invalid_ff, rsp_invalid_in;
   logic         adv;

   logic [8:0]   bits;
   logic [67:0]  iter_a, iter_b;
   logic [61:0]  words;
   logic [77:0]  cfull;
   logic [68:0]  iter69;
   logic [63:0]  mg;

   function automatic bk_type digit_group(input bk_type s, input int top);
      bk_type      t;
      logic [2:0]  rr;
      logic [10:0] dd;
      t  = s;
      rr = s.rem;
      for (int k = 0; k < 3; k++) begin
         dd = div_digit({rr, s.num[8*(top-k) +: 8]}, s.rule);
         t.quo[8*(top-k) +: 8] = dd[10:3];
         rr = dd[2:0];
      end
      t.rem = rr;
      return t;
   endfunction

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && !q_empty;

   // lengths, maximum, per-word bit lengths
   always_comb begin
      st_in[1]         = '0;
      st_in[1].rule    = q_word.rule;
      st_in[1].fin     = q_word.fin;
      st_in[1].fin_gas = q_word.fin_gas;
      st_in[1].fin_inv = q_word.fin_inv;
      st_in[1].mlen    = (q_word.mod_len > q_word.base_len) ? q_word.mod_len
                                                            : q_word.base_len;
      st_in[1].el_big  = q_word.exp_len > HEAD_LEN;
      st_in[1].el_off  = q_word.exp_len - HEAD_LEN;
      for (int j = 0; j < 4; j++) begin
         st_in[1].wlen[j] = bit_len64(q_word.head[64*j +: 64]);
      end
   end

   // iteration count, word count, squaring operand
   always_comb begin
      st_in[2] = st_ff[1];
      if (st_ff[1].wlen[3] != '0)      bits = 9'd192 + 9'(st_ff[1].wlen[3]);
      else if (st_ff[1].wlen[2] != '0) bits = 9'd128 + 9'(st_ff[1].wlen[2]);
      else if (st_ff[1].wlen[1] != '0) bits = 9'd64 + 9'(st_ff[1].wlen[1]);
      else                             bits = 9'(st_ff[1].wlen[0]);
      if (!st_ff[1].el_big)                iter_a = '0;
      else if (st_ff[1].rule == RULE_7883) iter_a = {st_ff[1].el_off, 4'b0};
      else                                 iter_a = {1'b0, st_ff[1].el_off, 3'b0};
      iter_b = (bits > 9'd1) ? iter_a + 68'(bits - 9'd1) : iter_a;
      st_in[2].iter = (iter_b == '0) ? 68'd1 : iter_b;
      words = 62'(st_ff[1].mlen >> 3) + 62'(st_ff[1].mlen[2:0] != 3'b0);
      st_in[2].sat = st_ff[1].mlen[63:38] != '0;
      st_in[2].x   = (st_ff[1].rule == RULE_198) ? st_ff[1].mlen[37:0] : words[37:0];
   end

   // square partial products, linear term
   always_comb begin
      st_in[3]       = st_ff[2];
      st_in[3].pp_hh = 38'(st_ff[2].x[37:19]) * 38'(st_ff[2].x[37:19]);
      st_in[3].pp_hl = 38'(st_ff[2].x[37:19]) * 38'(st_ff[2].x[18:0]);
      st_in[3].pp_ll = 38'(st_ff[2].x[18:0]) * 38'(st_ff[2].x[18:0]);
      st_in[3].lin   = (st_ff[2].mlen <= LEN_CAP) ? 47'(st_ff[2].mlen[37:0]) * LIN_198_MID
                                                  : 47'(st_ff[2].mlen[37:0]) * LIN_198_HIGH;
   end

   always_comb begin
      st_in[4]    = st_ff[3];
      st_in[4].sq = {st_ff[3].pp_hh, 38'b0} + 76'({st_ff[3].pp_hl, 20'b0})
                  + 76'(st_ff[3].pp_ll);
   end

   // complexity
   always_comb begin
      st_in[5] = st_ff[4];
      case (st_ff[4].rule)
         RULE_198: begin
            if (st_ff[4].mlen <= SQ_LIMIT_198)
               cfull = 78'(st_ff[4].sq);
            else if (st_ff[4].mlen <= LEN_CAP)
               cfull = 78'(st_ff[4].sq >> 2) + 78'(st_ff[4].lin) - OFF_198_MID;
            else
               cfull = 78'(st_ff[4].sq >> 4) + 78'(st_ff[4].lin) - OFF_198_HIGH;
         end
         RULE_2565: cfull = 78'(st_ff[4].sq);
         default:   cfull = (st_ff[4].mlen > HEAD_LEN) ? {1'b0, st_ff[4].sq, 1'b0}
                                                       : FLOOR_7883;
      endcase
      st_in[5].sat  = st_ff[4].sat | (cfull[77:69] != '0);
      st_in[5].cplx = cfull[68:0];
   end

   // complexity x iterations, 23-bit limbs
   always_comb begin
      st_in[6] = st_ff[5];
      iter69   = {1'b0, st_ff[5].iter};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            st_in[6].pp[3*i+j] = 46'(st_ff[5].cplx[23*i +: 23]) * 46'(iter69[23*j +: 23]);
         end
      end
   end

   always_comb begin
      st_in[7] = st_ff[6];
      for (int i = 0; i < 3; i++) begin
         st_in[7].row[i] = 92'(st_ff[6].pp[3*i]) + (92'(st_ff[6].pp[3*i+1]) << 23)
                         + (92'(st_ff[6].pp[3*i+2]) << 46);
      end
   end

   always_comb begin
      st_in[8]      = st_ff[7];
      st_in[8].prod = 138'(st_ff[7].row[0]) + (138'(st_ff[7].row[1]) << 23)
                    + (138'(st_ff[7].row[2]) << 46);
   end

   // saturation test; divide by 20 starts as a shift by two
   always_comb begin
      st_in[9]     = st_ff[8];
      st_in[9].rem = '0;
      st_in[9].quo = '0;
      case (st_ff[8].rule)
         RULE_198: begin
            st_in[9].sat = st_ff[8].sat | (st_ff[8].prod[137:64] >= DIV_198);
            st_in[9].num = st_ff[8].prod[73:2];
         end
         RULE_2565: begin
            st_in[9].sat = st_ff[8].sat | (st_ff[8].prod[137:64] >= DIV_2565);
            st_in[9].num = st_ff[8].prod[71:0];
         end
         default: begin
            st_in[9].sat = st_ff[8].sat | (st_ff[8].prod[137:64] >= DIV_7883);
            st_in[9].num = st_ff[8].prod[71:0];
         end
      endcase
   end

   always_comb st_in[10] = digit_group(st_ff[9], 8);
   always_comb st_in[11] = digit_group(st_ff[10], 5);
   always_comb st_in[12] = digit_group(st_ff[11], 2);

   always_comb begin
      mg             = min_gas(st_ff[NST].rule);
      rsp_invalid_in = 1'b0;
      if (st_ff[NST].fin) begin
         rsp_gas_in     = st_ff[NST].fin_gas;
         rsp_invalid_in = st_ff[NST].fin_inv;
      end else if (st_ff[NST].sat) begin
         rsp_gas_in = '1;
      end else if (st_ff[NST].quo[63:0] < mg) begin
         rsp_gas_in = mg;
      end else begin
         rsp_gas_in = st_ff[NST].quo[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NST-1:1], q_pop};
         rsp_valid_ff <= vld_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff          <= st_in;
         rsp_gas_ff     <= rsp_gas_in;
         rsp_invalid_ff <= rsp_invalid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gas     = rsp_gas_ff;
   assign rsp_invalid = rsp_invalid_ff;

endmodule

// ===== hw/rtl/modexp_gas_cost_core.sv =====
`timescale 1ns / 1ps

// Modexp precompile gas pricing from pre-extracted header values. One request word is taken
// per cycle while the queue is not full; one response word is returned per request, in order.
// The front end classifies each word (early minimum, length cap, oversize) and pushes it into
// a small queue; the back end is a 12-stage pipeline (bit length, iteration count, complexity
// square, 69x68-bit product in 23-bit limbs, saturation test, divide by 1/3/20 three
// byte-digits per stage) plus an output register. A word passes through the queue, the pipeline
// stages and the output register before rsp_valid rises. The back end stalls as a whole on
// rsp_ready; meanwhile the queue takes up to QUEUE_DEPTH words before req_ready drops.
// Registers: 0x0 complexity rule (0, 1, 2; 3 acts as 2), 0x4 length cap enable.

module modexp_gas_cost_core
   import mgc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = MGC_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_base_length,
   input  logic        req_base_length_over,
   input  logic [63:0] req_exponent_length,
   input  logic        req_exponent_length_over,
   input  logic [63:0] req_modulus_length,
   input  logic        req_modulus_length_over,
   input  logic [63:0] req_head_word3,
   input  logic [63:0] req_head_word2,
   input  logic [63:0] req_head_word1,
   input  logic [63:0] req_head_word0,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_gas,
   output logic        rsp_invalid
);

   logic [1:0] rule_ff;
   logic       cap_ff;
   logic       csr_wr;
   cls_type    cls_word;
   cls_type    q_head;
   logic       q_full, q_empty, q_pop, push;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= RULE_RESET;
         cap_ff  <= CAP_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_RULE: rule_ff <= csr_pwdata[1:0];
            REG_CAP:  cap_ff  <= csr_pwdata[0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RULE: csr_prdata = {30'b0, rule_ff};
         REG_CAP:  csr_prdata = {31'b0, cap_ff};
         default:  csr_prdata = '0;
      endcase
   end

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   mgc_front u_front (
      .cfg_rule             (rule_ff),
      .cfg_cap              (cap_ff),
      .base_length          (req_base_length),
      .base_length_over     (req_base_length_over),
      .exponent_length      (req_exponent_length),
      .exponent_length_over (req_exponent_length_over),
      .modulus_length       (req_modulus_length),
      .modulus_length_over  (req_modulus_length_over),
      .head_word3           (req_head_word3),
      .head_word2           (req_head_word2),
      .head_word1           (req_head_word1),
      .head_word0           (req_head_word0),
      .word                 (cls_word)
   );

   mgc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (cls_word),
      .pop       (q_pop),
      .head_word (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   mgc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_word      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_gas     (rsp_gas),
      .rsp_invalid (rsp_invalid)
   );

   a_inv_zero_gas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_gas == '0)
      else $error("invalid word carries nonzero gas");

   a_inv_needs_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> cap_ff)
      else $error("invalid flagged with length cap off");

   a_floor_7883: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid && rule_ff[1] |-> rsp_gas >= MIN_GAS_7883)
      else $error("gas below floor");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !q_pop)
      else $error("queue popped while empty");

endmodule

// ===== tb/mgc_checker.sv =====
`timescale 1ns / 1ps

module mgc_checker
   import mgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_base_length,
   input  logic        req_base_length_over,
   input  logic [63:0] req_exponent_length,
   input  logic        req_exponent_length_over,
   input  logic [63:0] req_modulus_length,
   input  logic        req_modulus_length_over,
   input  logic [63:0] req_head_word3,
   input  logic [63:0] req_head_word2,
   input  logic [63:0] req_head_word1,
   input  logic [63:0] req_head_word0,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_gas,
   input  logic        rsp_invalid,
   output int          errors,
   output int          pending
);

   typedef struct {
      bit [63:0] gas;
      bit        invalid;
   } price_type;

   price_type price_q[$];
   bit [1:0]  rule_reg;
   bit        cap_reg;

   function automatic int unsigned bit_width(input bit [63:0] x);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = i + 1;
      end
      return n;
   endfunction

   function automatic price_type price_word(input bit [1:0] rule_sel, input bit cap);
      price_type   p;
      bit [1:0]    r;
      bit [63:0]   bl, el, ml, mn, m, wds;
      bit          bo, eo, mo;
      bit [255:0]  it, cx, sq, q, dv;
      int unsigned bits;
      bl = req_base_length;
      el = req_exponent_length;
      ml = req_modulus_length;
      bo = req_base_length_over;
      eo = req_exponent_length_over;
      mo = req_modulus_length_over;
      r = (rule_sel == RULE_198 || rule_sel == RULE_2565) ? rule_sel : RULE_7883;
      mn = (r == RULE_7883) ? 64'd500 : (r == RULE_2565 ? 64'd200 : 64'd0);
      dv = (r == RULE_7883) ? 256'd1 : (r == RULE_2565 ? 256'd3 : 256'd20);
      p.gas = '0;
      p.invalid = 1'b0;
      if (r != RULE_7883 && bl == 0 && !bo && ml == 0 && !mo) begin
         p.gas = mn;
         return p;
      end
      if (cap) begin
         if (bo || eo || mo || bl > 1024 || el > 1024 || ml > 1024) begin
            p.invalid = 1'b1;
            return p;
         end
      end else if (bo || eo || mo) begin
         p.gas = '1;
         return p;
      end
      if (req_head_word3 != 0) bits = 192 + bit_width(req_head_word3);
      else if (req_head_word2 != 0) bits = 128 + bit_width(req_head_word2);
      else if (req_head_word1 != 0) bits = 64 + bit_width(req_head_word1);
      else bits = bit_width(req_head_word0);
      it = '0;
      if (el > 32) it = ((r == RULE_7883) ? 256'd16 : 256'd8) * 256'(el - 64'd32);
      if (bits > 1) it = it + 256'(bits - 1);
      if (it == 0) it = 256'd1;
      m = (ml > bl) ? ml : bl;
      wds = (m >> 3) + ((m[2:0] != 0) ? 64'd1 : 64'd0);
      if (r == RULE_7883) begin
         cx = (m > 32) ? 256'd2 * 256'(wds) * 256'(wds) : 256'd16;
      end else if (r == RULE_2565) begin
         cx = 256'(wds) * 256'(wds);
      end else begin
         sq = 256'(m) * 256'(m);
         if (m <= 64) cx = sq;
         else if (m <= 1024) cx = (sq >> 2) + 256'd96 * 256'(m) - 256'd3072;
         else cx = (sq >> 4) + 256'd480 * 256'(m) - 256'd199680;
      end
      q = (cx * it) / dv;
      if (q[255:64] != 0) p.gas = '1;
      else p.gas = (q[63:0] < mn) ? mn : q[63:0];
      return p;
   endfunction

   assign pending = price_q.size();

   always @(posedge clock) begin
      price_type e;
      if (reset) begin
         rule_reg <= RULE_RESET;
         cap_reg  <= CAP_RESET;
         price_q.delete();
         errors   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_paddr[2] == REG_RULE) rule_reg <= csr_pwdata[1:0];
            else rule_reg <= rule_reg;
            if (csr_paddr[2] == REG_CAP) cap_reg <= csr_pwdata[0];
         end
         if (req_valid && req_ready) price_q.push_back(price_word(rule_reg, cap_reg));
         if (rsp_valid && rsp_ready) begin
            if (price_q.size() == 0) begin
               $error("unexpected word: gas %h invalid %b", rsp_gas, rsp_invalid);
               errors <= errors + 1;
            end else begin
               e = price_q.pop_front();
               if (rsp_gas !== e.gas || rsp_invalid !== e.invalid) errors <= errors + 1;
               if (rsp_gas !== e.gas)
                  $error("gas: expected %h actual %h", e.gas, rsp_gas);
               if (rsp_invalid !== e.invalid)
                  $error("invalid: expected %b actual %b", e.invalid, rsp_invalid);
            end
         end
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mgc_pkg::*;

   localparam logic [1:0] RULE_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_base_length = '0, req_exponent_length = '0, req_modulus_length = '0;
   logic        req_base_length_over = 1'b0, req_exponent_length_over = 1'b0;
   logic        req_modulus_length_over = 1'b0;
   logic [63:0] req_head_word3 = '0, req_head_word2 = '0, req_head_word1 = '0;
   logic [63:0] req_head_word0 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_gas;
   logic        rsp_invalid;
   int          errors, pending;
   bit          quiet = 1'b0;
   int          hold_req = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   modexp_gas_cost_core u_top (.*);

   mgc_checker u_chk (.*);

   initial begin
      #3_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 200;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 10);
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] val);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = addr; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_mode(input logic [1:0] rule, input bit cap);
      drain();
      csr_write({REG_RULE, 2'b00}, {30'($urandom), 2'b00} | 32'(rule));
      csr_write({REG_CAP, 2'b00}, {31'($urandom), 1'b0} | 32'(cap));
   endtask

   task automatic send_word(input logic [63:0] bl, input bit bo, input logic [63:0] el,
                            input bit eo, input logic [63:0] ml, input bit mo,
                            input logic [255:0] head);
      if (!quiet && $urandom_range(99) < 3) begin
         req_valid = 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_base_length = bl; req_base_length_over = bo;
      req_exponent_length = el; req_exponent_length_over = eo;
      req_modulus_length = ml; req_modulus_length_over = mo;
      {req_head_word3, req_head_word2, req_head_word1, req_head_word0} = head;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic logic [63:0] rand_len();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 10) return 64'd0;
      if (k < 20) return 64'd1024 + 64'($urandom_range(2)) - 64'd1;
      if (k < 75) return 64'($urandom_range(1100));
      if (k < 88) return 64'($urandom_range(32'hfffff));
      return {$urandom, $urandom};
   endfunction

   function automatic logic [255:0] rand_head();
      logic [255:0] h;
      h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return h >> $urandom_range(255);
   endfunction

   task automatic send_random();
      send_word(rand_len(), $urandom_range(99) < 4, rand_len(), $urandom_range(99) < 4,
                rand_len(), $urandom_range(99) < 4, rand_head());
   endtask

   task automatic send_directed();
      send_word('0, 1'b0, '0, 1'b0, '0, 1'b0, '0);
      send_word('0, 1'b0, 64'd40, 1'b0, '0, 1'b0, '1);
      send_word(64'd1, 1'b0, 64'd1, 1'b0, 64'd1, 1'b0, 256'd1);
      send_word(64'd32, 1'b0, 64'd32, 1'b0, 64'd33, 1'b0, 256'd2);
      send_word(64'd64, 1'b0, 64'd33, 1'b0, 64'd65, 1'b0, {64'd1, 192'd0});
      send_word(64'd1024, 1'b0, 64'd1024, 1'b0, 64'd1024, 1'b0, '1);
      send_word(64'd1025, 1'b0, 64'd1, 1'b0, 64'd8, 1'b0, 256'd3);
      send_word(64'd8, 1'b0, 64'd1025, 1'b0, 64'd8, 1'b0, 256'd3);
      send_word(64'd8, 1'b0, 64'd1, 1'b0, 64'd1025, 1'b0, 256'd3);
      send_word(64'd8, 1'b1, 64'd1, 1'b0, 64'd8, 1'b0, 256'd3);
      send_word(64'd8, 1'b0, 64'd1, 1'b1, 64'd8, 1'b0, 256'd3);
      send_word('0, 1'b0, 64'd1, 1'b0, '0, 1'b1, 256'd3);
      send_word('1, 1'b0, '1, 1'b0, '1, 1'b0, '1);
      send_word('1, 1'b0, '0, 1'b0, '0, 1'b0, '0);
      send_word(64'd100, 1'b0, 64'd200, 1'b0, '0, 1'b0,
                {128'd0, 64'h8000_0000_0000_0000, 64'd0});
      send_word(64'd7, 1'b0, 64'd5, 1'b0, 64'd9, 1'b0, {64'd0, 64'd5, 128'd0});
      send_word(64'd4096, 1'b0, 64'd2, 1'b0, 64'd3, 1'b0, 256'd0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_directed();
      for (int i = 0; i < 120; i++) send_random();
      set_mode(RULE_198, 1'b1);
      send_directed();
      for (int i = 0; i < 100; i++) send_random();
      set_mode(RULE_2565, 1'b0);
      send_directed();
      quiet = 1'b1;
      for (int i = 0; i < 120; i++) send_random();
      quiet = 1'b0;
      hold_req = hold_req + 1;
      for (int i = 0; i < 60; i++) send_random();
      set_mode(RULE_SPARE, 1'b0);
      send_directed();
      for (int i = 0; i < 100; i++) send_random();
      set_mode(RULE_198, 1'b0);
      send_directed();
      for (int i = 0; i < 120; i++) send_random();
      set_mode(RULE_7883, 1'b0);
      send_directed();
      for (int i = 0; i < 100; i++) send_random();
      set_mode(RULE_2565, 1'b1);
      send_directed();
      for (int i = 0; i < 100; i++) send_random();
      set_mode(RULE_7883, 1'b1);
      for (int i = 0; i < 100; i++) send_random();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
